// ===== src/assert_macros.svh =====
// assertion macros shared by the link table rtl
// no dependencies; taken in by `include where a module checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== src/lpt_pkg.sv =====
// types and codes of the mac pair link table
// no dependencies; used by every module of the block
package lpt_pkg;

  localparam int MAC_W       = 48;
  localparam int TOTAL_W     = 6;
  localparam int MAX_RESULTS = 32;

  // request modes
  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_CHECK  = 3'd2;
  localparam logic [2:0] MODE_PEERS  = 3'd3;
  localparam logic [2:0] MODE_EDGES  = 3'd4;

  // add status codes
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_EQUAL   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // row operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_REMOVE = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  typedef struct packed {
    logic [2:0]       mode;
    logic [MAC_W-1:0] mac_a;
    logic [MAC_W-1:0] mac_b;
  } lpt_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               present;
    logic               item_valid;
    logic [MAC_W-1:0]   edge_src;
    logic [MAC_W-1:0]   edge_dst;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } lpt_rsp_t;

  typedef struct packed {
    logic             used;
    logic [MAC_W-1:0] left;
    logic [MAC_W-1:0] right;
  } lpt_entry_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [MAC_W-1:0] key_a;
    logic [MAC_W-1:0] key_b;
  } lpt_ctl_t;

  typedef struct packed {
    logic pair_hit;
    logic left_hit;
    logic right_hit;
  } lpt_stat_t;

endpackage

// ===== src/lpt_cell.sv =====
// one cell of the pair row: holds one pair and compares it with the key
// depends on lpt_pkg
module lpt_cell import lpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lpt_ctl_t   ctl,
  input  logic       shift_en,
  input  lpt_entry_t prev,
  input  lpt_entry_t next,
  input  lpt_entry_t wrap,
  output lpt_entry_t ent,
  output lpt_stat_t  stat
);

  logic             used;
  logic [MAC_W-1:0] left;
  logic [MAC_W-1:0] right;
  lpt_entry_t       ent_next;

  assign ent = '{used: used, left: left, right: right};

  always_comb begin
    ent_next = ent;
    case (ctl.op)
      CELL_INSERT: ent_next = prev;
      CELL_REMOVE: begin
        if (shift_en) ent_next = next;
      end
      CELL_ROTATE: begin
        // last used cell closes the ring with the head entry
        if (used) ent_next = next.used ? next : wrap;
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      used <= ent_next.used;
    end
  end

  always_ff @(posedge clk) begin
    left  <= ent_next.left;
    right <= ent_next.right;
  end

  assign stat.left_hit  = (left == ctl.key_a);
  assign stat.right_hit = (right == ctl.key_a);
  assign stat.pair_hit  = used && (((left == ctl.key_a) && (right == ctl.key_b)) ||
                                   ((left == ctl.key_b) && (right == ctl.key_a)));

endmodule

// ===== src/lpt_chain.sv =====
// row of pair cells wired neighbor to neighbor, head at cell 0
// depends on lpt_pkg and lpt_cell
module lpt_chain import lpt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  lpt_ctl_t         ctl,
  input  logic [SLOTS-1:0] shift_mask,
  output logic [SLOTS-1:0] hits,
  output logic [SLOTS-1:0] used_vec,
  output lpt_entry_t       head,
  output lpt_stat_t        head_stat
);

  lpt_entry_t ent  [SLOTS];
  lpt_stat_t  stat [SLOTS];
  lpt_entry_t ins_entry;

  // new pair enters at the head
  assign ins_entry = '{used: 1'b1, left: ctl.key_a, right: ctl.key_b};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lpt_entry_t prev_ent;
    lpt_entry_t next_ent;

    if (i == 0) begin : g_first
      assign prev_ent = ins_entry;
    end else begin : g_mid
      assign prev_ent = ent[i-1];
    end

    if (i == SLOTS - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ent[i+1];
    end

    lpt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .shift_en (shift_mask[i]),
      .prev     (prev_ent),
      .next     (next_ent),
      .wrap     (ent[0]),
      .ent      (ent[i]),
      .stat     (stat[i])
    );

    assign hits[i]     = stat[i].pair_hit;
    assign used_vec[i] = ent[i].used;
  end

  assign head      = ent[0];
  assign head_stat = stat[0];

endmodule

// ===== src/mac_pair_link_table_unit.sv =====
// top level of the mac pair link table: request control, row of cells, result register
// depends on lpt_pkg, lpt_chain, lpt_cell and assert_macros.svh
//
// add, remove, check and unused modes give a single result: the request is registered,
//   compared in the match state and answered from the exec state, which waits on a full
//   result register; a new request is taken only once the control is back in idle
// list modes: match, a count pass over the stored pairs, then an emit pass with at most one
//   edge per cycle, held while the result register is full; both passes rotate the row once
// reset clears every valid mark in the row and the pair count at once, no clearing pass
`include "assert_macros.svh"

module mac_pair_link_table_unit import lpt_pkg::*; #(
  parameter int PAIR_SLOTS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  lpt_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output lpt_rsp_t rsp_data
);

  localparam int CW    = $clog2(PAIR_SLOTS + 1);
  localparam int STEPS = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;

  // control states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]            state, state_next;
  lpt_req_t              req_q;
  logic [PAIR_SLOTS-1:0] hit_q;
  logic                  eq_q;
  logic                  full_q;
  logic [CW-1:0]         pair_count, pair_count_next;
  logic [CW-1:0]         idx, idx_next;
  logic                  half, half_next;
  logic [TOTAL_W-1:0]    total, total_next;
  logic [TOTAL_W-1:0]    sent, sent_next;
  logic                  rsp_load;
  lpt_rsp_t              rsp_data_next;

  logic [1:0]            cell_op;
  logic [PAIR_SLOTS-1:0] shift_mask;
  logic [PAIR_SLOTS-1:0] hits;
  logic [PAIR_SLOTS-1:0] used_vec;
  lpt_entry_t            head;
  lpt_stat_t             head_stat;
  lpt_ctl_t              ctl;

  logic                  out_free;
  logic                  list_mode;
  logic                  idx_last;
  logic                  any_hit;
  logic [1:0]            edge_add;
  logic [TOTAL_W:0]      total_sum;
  logic                  want;
  logic                  emit;

  // the row of pairs; key is the held request
  assign ctl = '{op: cell_op, key_a: req_q.mac_a, key_b: req_q.mac_b};

  lpt_chain #(
    .SLOTS (PAIR_SLOTS)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .shift_mask (shift_mask),
    .hits       (hits),
    .used_vec   (used_vec),
    .head       (head),
    .head_stat  (head_stat)
  );

  // remove closes the gap: every cell from the hit onward pulls from its successor
  always_comb begin
    shift_mask = hit_q;
    for (int s = 0; s < STEPS; s++) begin
      shift_mask = shift_mask | (shift_mask << (1 << s));
    end
  end

  // one request in flight at a time
  assign req_stall = (state != S_IDLE);

  // result register empties this cycle or is already empty
  assign out_free  = !rsp_valid || !rsp_stall;
  assign list_mode = (req_q.mode == MODE_PEERS) || (req_q.mode == MODE_EDGES);
  assign idx_last  = (idx == pair_count - CW'(1));
  assign any_hit   = |hit_q;

  // edges the head pair contributes to a list
  assign edge_add  = (req_q.mode == MODE_EDGES) ? 2'd2 :
                     (2'(head_stat.left_hit) + 2'(head_stat.right_hit));
  assign total_sum = {1'b0, total} + (TOTAL_W+1)'(edge_add);

  // right-to-left edge first, then left-to-right
  assign want = (req_q.mode == MODE_EDGES) ||
                (half ? head_stat.left_hit : head_stat.right_hit);
  assign emit = want && (sent != total);

  always_comb begin
    state_next      = state;
    pair_count_next = pair_count;
    idx_next        = idx;
    half_next       = half;
    total_next      = total;
    sent_next       = sent;
    cell_op         = CELL_HOLD;
    rsp_load        = 1'b0;
    rsp_data_next   = '0;
    rsp_data_next.last = 1'b1;

    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_MATCH;
      end

      S_MATCH: begin
        idx_next   = '0;
        total_next = '0;
        sent_next  = '0;
        if (list_mode && (pair_count != '0)) begin
          state_next = S_COUNT;
        end else begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          case (req_q.mode)
            MODE_ADD: begin
              if (eq_q) begin
                rsp_data_next.status = ST_EQUAL;
              end else if (any_hit) begin
                rsp_data_next.status  = ST_PRESENT;
                rsp_data_next.present = 1'b1;
              end else if (full_q) begin
                rsp_data_next.status = ST_FULL;
              end else begin
                rsp_data_next.status = ST_ADDED;
                cell_op              = CELL_INSERT;
                pair_count_next      = pair_count + CW'(1);
              end
            end
            MODE_REMOVE: begin
              rsp_data_next.present = any_hit;
              if (any_hit) begin
                cell_op         = CELL_REMOVE;
                pair_count_next = pair_count - CW'(1);
              end
            end
            MODE_CHECK: rsp_data_next.present = any_hit;
            // empty lists and unused modes give the all-zero final result
            default: rsp_data_next.present = 1'b0;
          endcase
        end
      end

      S_COUNT: begin
        // first trip round the ring: total of the list, capped at the result limit
        cell_op    = CELL_ROTATE;
        idx_next   = idx + CW'(1);
        total_next = (total_sum > (TOTAL_W+1)'(MAX_RESULTS)) ?
                     TOTAL_W'(MAX_RESULTS) : total_sum[TOTAL_W-1:0];
        if (idx_last) begin
          idx_next   = '0;
          half_next  = 1'b0;
          sent_next  = '0;
          state_next = (total_next == '0) ? S_EXEC : S_EMIT;
        end
      end

      S_EMIT: begin
        // second trip: at most one edge per cycle from the head, waits on a full result register
        if (!(emit && !out_free)) begin
          if (emit) begin
            rsp_load                 = 1'b1;
            rsp_data_next.item_valid = 1'b1;
            rsp_data_next.edge_src   = half ? head.left : head.right;
            rsp_data_next.edge_dst   = half ? head.right : head.left;
            rsp_data_next.total      = total;
            rsp_data_next.last       = ((sent + TOTAL_W'(1)) == total);
            sent_next                = sent + TOTAL_W'(1);
          end
          if (!half) begin
            half_next = 1'b1;
          end else begin
            half_next = 1'b0;
            cell_op   = CELL_ROTATE;
            idx_next  = idx + CW'(1);
            if (idx_last) state_next = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pair_count <= '0;
      idx        <= '0;
      half       <= 1'b0;
      total      <= '0;
      sent       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pair_count <= pair_count_next;
      idx        <= idx_next;
      half       <= half_next;
      total      <= total_next;
      sent       <= sent_next;
      rsp_valid  <= rsp_load || (rsp_valid && rsp_stall);
    end
  end

  // request, compare results and result payload
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) req_q <= req_data;
    if (state == S_MATCH) begin
      hit_q  <= hits;
      eq_q   <= (req_q.mac_a == req_q.mac_b);
      full_q <= used_vec[PAIR_SLOTS-1];
    end
    if (rsp_load) rsp_data <= rsp_data_next;
  end

  // row stays compacted from the head and agrees with the pair count
  `ASSERT_NEVER(a_row_compact, clk, rst, ((used_vec >> 1) & ~used_vec) != '0)
  `ASSERT_CLK(a_count_match, clk, rst, $countones(used_vec) == pair_count)
  // a pair is never stored twice, so at most one cell hits
  `ASSERT_CLK(a_single_hit, clk, rst, (state == S_MATCH) |-> $onehot0(hits))
  // never more edges than the announced total
  `ASSERT_NEVER(a_sent_bound, clk, rst, sent > total)

endmodule
